>>> hw/rtl/cps_pkg.sv
// Package for the critical path scheduler: sizes, time width and saturating helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package cps_pkg;
  localparam int unsigned MaxTasksDef     = 16;
  localparam int unsigned DurationBitsDef = 16;
  localparam int unsigned TimeW           = 20;
  localparam int unsigned CountW          = 5;
  localparam int unsigned ResultLimit     = 16;
  localparam logic [TimeW-1:0] TimeMax    = {TimeW{1'b1}};

  localparam logic OpLoad = 1'b0;
  localparam logic OpRun  = 1'b1;

  // Datapath phase selects, driven by the controller.
  typedef enum logic [2:0] {
    PH_INIT_FWD, PH_FWD, PH_PROJ, PH_INIT_BWD, PH_BWD, PH_ROOT, PH_WALK
  } cps_phase_e;

  typedef struct packed {
    cps_phase_e phase;
    logic       step;    // perform one element step at the current indices
    logic       clear;   // reset indices, accumulators and marks
  } cps_cmd_t;

  typedef struct packed {
    logic done;       // current phase finished
    logic found;      // root search hit a zero-slack root
    logic emit;       // a result is on the output this cycle
    logic walk_end;   // walk has finished
  } cps_sts_t;

  function automatic logic [TimeW-1:0] add_sat(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] sub_sat(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/cps_datapath.sv
// Datapath of the critical path scheduler: task stores, time stores, relaxation and walk.
// Depends on cps_pkg; sequenced by cps_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module cps_datapath import cps_pkg::*; #(
  parameter int unsigned MaxTasks     = MaxTasksDef,
  parameter int unsigned DurationBits = DurationBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire logic [3:0]              load_index_i,
  input  wire logic [15:0]             load_duration_i,
  input  wire logic [15:0]             load_mask_i,
  input  wire logic [CountW-1:0]       cfg_count_i,
  input  wire cps_cmd_t                cmd_i,
  output cps_sts_t                     sts_o,
  output logic [3:0]                   path_task_o,
  output logic [TimeW-1:0]             early_finish_o,
  output logic [TimeW-1:0]             late_start_o
);
  localparam int unsigned IdxW = $clog2(MaxTasks);
  localparam int unsigned NW   = $clog2(MaxTasks + 1);
  localparam int unsigned MaskW = (MaxTasks < 16) ? MaxTasks : 16;

  logic [DurationBits-1:0] dur_q [MaxTasks];
  logic [MaxTasks-1:0]     row_q [MaxTasks];
  logic [TimeW-1:0]        ef_q  [MaxTasks];
  logic [TimeW-1:0]        ls_q  [MaxTasks];
  logic [MaxTasks-1:0]     vis_q;
  logic [IdxW-1:0]         stk_q [MaxTasks];
  logic [NW-1:0]           sp_q;
  logic [NW-1:0]           n_q;
  logic [IdxW-1:0]         pass_q, i_q, p_q;
  logic [TimeW-1:0]        acc_q, proj_q;
  logic [IdxW-1:0]         cur_q, root_q;
  logic                    cur_ok_q;
  logic [4:0]              k_q;

  // Effective task count: 0 acts as 1, clamp at MaxTasks.
  logic [NW-1:0] n_eff;
  always_comb begin
    if (cfg_count_i == '0) n_eff = NW'(1);
    else if ({27'd0, cfg_count_i} > MaxTasks) n_eff = NW'(MaxTasks);
    else n_eff = NW'(cfg_count_i);
  end

  logic [MaxTasks-1:0] live;
  always_comb for (int b = 0; b < MaxTasks; b++) live[b] = (b < n_q);

  // Column of the matrix for task i: predecessors of i.
  logic [MaxTasks-1:0] col_i;
  always_comb for (int b = 0; b < MaxTasks; b++) col_i[b] = row_q[b][i_q] & live[b];
  logic is_root_i, is_leaf_i, edge_pi, edge_ip;
  logic [IdxW-1:0] last;
  assign is_root_i = (col_i == '0);
  assign is_leaf_i = ((row_q[i_q] & live) == '0);
  assign edge_pi   = row_q[p_q][i_q] & live[p_q];
  assign edge_ip   = row_q[i_q][p_q] & live[p_q];
  assign last      = IdxW'(n_q - NW'(1));
  logic [TimeW-1:0] dur_i, dur_p;
  assign dur_i = TimeW'(dur_q[i_q]);
  assign dur_p = TimeW'(dur_q[p_q]);
  // Backward sweep runs i from high to low.
  logic [IdxW-1:0] bi;
  assign bi = last - i_q;
  logic [MaxTasks-1:0] walk_cand;
  always_comb begin
    for (int b = 0; b < MaxTasks; b++)
      walk_cand[b] = row_q[cur_q][b] & live[b] & ~vis_q[b] & (ls_q[b] == ef_q[cur_q]);
  end

  logic [TimeW-1:0] cand_f, bwd_lf;
  assign cand_f = add_sat(ef_q[p_q], dur_i);

  // Running minimum of successor late starts for the backward sweep.
  always_comb begin
    bwd_lf = acc_q;
    if ((row_q[bi][p_q] & live[p_q]) && ls_q[p_q] < acc_q) bwd_lf = ls_q[p_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < MaxTasks; b++) begin
        ef_q[b] <= '0;
        ls_q[b] <= '0;
      end
      vis_q <= '0; sp_q <= '0; n_q <= NW'(1); pass_q <= '0; i_q <= '0; p_q <= '0;
      acc_q <= '0; proj_q <= '0; cur_q <= '0; root_q <= '0; cur_ok_q <= 1'b0;
      k_q <= '0; sts_o <= '0; path_task_o <= '0; early_finish_o <= '0; late_start_o <= '0;
    end else begin
      sts_o <= '0;
      // Load one task.
      if (load_i && ({28'd0, load_index_i} < MaxTasks)) begin
        dur_q[IdxW'(load_index_i)] <= DurationBits'(load_duration_i);
        row_q[IdxW'(load_index_i)] <= MaxTasks'(load_mask_i[MaskW-1:0]);
      end
      if (cmd_i.clear) begin
        n_q <= n_eff; pass_q <= '0; i_q <= '0; p_q <= '0; acc_q <= TimeMax;
        vis_q <= '0; sp_q <= '0; k_q <= '0; cur_ok_q <= 1'b0; proj_q <= '0;
      end else if (cmd_i.step) begin
        unique case (cmd_i.phase)
          PH_INIT_FWD: begin
            ef_q[i_q] <= is_root_i ? dur_i : '0;
            if (i_q == last) begin i_q <= '0; sts_o.done <= 1'b1; end
            else i_q <= i_q + 1'b1;
          end
          PH_FWD: begin
            if (edge_pi && cand_f > ef_q[i_q]) ef_q[i_q] <= cand_f;
            if (p_q != last) p_q <= p_q + 1'b1;
            else begin
              p_q <= '0;
              if (i_q != last) i_q <= i_q + 1'b1;
              else begin
                i_q <= '0;
                if (pass_q != last) pass_q <= pass_q + 1'b1;
                else begin pass_q <= '0; sts_o.done <= 1'b1; end
              end
            end
          end
          PH_PROJ: begin
            if (ef_q[i_q] > proj_q) proj_q <= ef_q[i_q];
            if (i_q == last) begin i_q <= '0; sts_o.done <= 1'b1; end
            else i_q <= i_q + 1'b1;
          end
          PH_INIT_BWD: begin
            ls_q[i_q] <= sub_sat(proj_q, dur_i);
            if (i_q == last) begin i_q <= '0; sts_o.done <= 1'b1; end
            else i_q <= i_q + 1'b1;
          end
          PH_BWD: begin
            // i_q here counts the sweep position; the task is bi.
            if (p_q != last) begin
              p_q <= p_q + 1'b1; acc_q <= bwd_lf;
            end else begin
              p_q <= '0; acc_q <= TimeMax;
              if ((row_q[bi] & live) != '0) ls_q[bi] <= sub_sat(bwd_lf, TimeW'(dur_q[bi]));
              if (i_q != last) i_q <= i_q + 1'b1;
              else begin
                i_q <= '0;
                if (pass_q != last) pass_q <= pass_q + 1'b1;
                else begin pass_q <= '0; sts_o.done <= 1'b1; end
              end
            end
          end
          PH_ROOT: begin
            if (is_root_i && ls_q[i_q] == '0) begin
              root_q <= i_q; cur_q <= i_q; vis_q[i_q] <= 1'b1;
              sts_o.found <= 1'b1; sts_o.done <= 1'b1; sts_o.emit <= 1'b1;
              path_task_o <= 4'(i_q); early_finish_o <= ef_q[i_q];
              late_start_o <= ls_q[i_q];
              stk_q[0] <= i_q; sp_q <= NW'(0); cur_ok_q <= 1'b1; k_q <= 5'd1;
              i_q <= '0;
            end else if (i_q == last) begin
              sts_o.done <= 1'b1; sts_o.emit <= 1'b1;
              path_task_o <= '0; early_finish_o <= '0; late_start_o <= '0;
            end else i_q <= i_q + 1'b1;
          end
          PH_WALK: begin
            // cur_q is the popped task; p_q scans its successors.
            if (k_q >= 5'(ResultLimit)) sts_o.walk_end <= 1'b1;
            else if (walk_cand[p_q]) begin
              vis_q[p_q] <= 1'b1; k_q <= k_q + 1'b1; sts_o.emit <= 1'b1;
              path_task_o <= 4'(p_q); early_finish_o <= ef_q[p_q];
              late_start_o <= ls_q[p_q];
              if (sp_q < NW'(MaxTasks)) begin
                stk_q[sp_q[IdxW-1:0]] <= p_q; sp_q <= sp_q + 1'b1;
              end
              if (p_q != last) p_q <= p_q + 1'b1;
              else p_q <= '0;
              if (p_q == last) cur_ok_q <= 1'b0;
              if (p_q == last && sp_q == NW'(MaxTasks)) sts_o.walk_end <= 1'b0;
            end else if (p_q != last) p_q <= p_q + 1'b1;
            else begin p_q <= '0; cur_ok_q <= 1'b0; end
            // Pop the next task when the scan of the current one is over.
            if (!cur_ok_q && k_q < 5'(ResultLimit)) begin
              if (sp_q == '0) sts_o.walk_end <= 1'b1;
              else begin
                cur_q <= stk_q[sp_q[IdxW-1:0] - 1'b1]; sp_q <= sp_q - 1'b1;
                cur_ok_q <= 1'b1; p_q <= '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  logic unused;
  assign unused = ^{edge_ip, dur_p, root_q, is_leaf_i};
endmodule
`default_nettype wire

>>> hw/rtl/cps_ctrl.sv
// Controller of the critical path scheduler: sequences the datapath phases of a run.
// Depends on cps_pkg; drives cps_datapath.
`timescale 1ns / 1ps
`default_nettype none
module cps_ctrl import cps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     run_i,
  input  wire cps_sts_t sts_i,
  output cps_cmd_t      cmd_o,
  output logic          busy_o,
  output logic          emit_o,
  output logic          status_o,
  output logic          last_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_RUN, S_WALK, S_FLUSH
  } state_e;

  state_e     state_q;
  cps_phase_e phase_q;
  logic       pend_q;   // a walk result is held back to find out if it is the last

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; phase_q <= PH_INIT_FWD; pend_q <= 1'b0;
      emit_o <= 1'b0; status_o <= 1'b0; last_o <= 1'b0;
    end else begin
      emit_o <= 1'b0; status_o <= 1'b0; last_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (run_i) state_q <= S_CLEAR;
        S_CLEAR: begin state_q <= S_RUN; phase_q <= PH_INIT_FWD; end
        S_RUN: if (sts_i.done) begin
          unique case (phase_q)
            PH_INIT_FWD: phase_q <= PH_FWD;
            PH_FWD:      phase_q <= PH_PROJ;
            PH_PROJ:     phase_q <= PH_INIT_BWD;
            PH_INIT_BWD: phase_q <= PH_BWD;
            PH_BWD:      phase_q <= PH_ROOT;
            PH_ROOT: begin
              if (sts_i.found) begin
                pend_q <= 1'b1; phase_q <= PH_WALK; state_q <= S_WALK;
              end else begin
                emit_o <= 1'b1; status_o <= 1'b1; last_o <= 1'b1; state_q <= S_IDLE;
              end
            end
            default: phase_q <= PH_INIT_FWD;
          endcase
        end
        S_WALK: begin
          // Release the held result once the next one or the end is known.
          if (sts_i.walk_end) begin
            emit_o <= 1'b1; last_o <= 1'b1; pend_q <= 1'b0; state_q <= S_IDLE;
          end else if (sts_i.emit) begin
            emit_o <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Hold the datapath for the cycle in which a phase reports done, so the next
  // phase starts from cleared indices.
  assign busy_o = (state_q != S_IDLE);
  always_comb begin
    cmd_o.phase = phase_q;
    cmd_o.clear = (state_q == S_CLEAR);
    cmd_o.step  = (state_q == S_RUN && !sts_i.done) || (state_q == S_WALK && !sts_i.walk_end);
  end

  logic unused;
  assign unused = pend_q;

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> $past(busy_o)) else $error("result without a run");
  a_last_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> emit_o) else $error("last flag without result");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o |-> last_o) else $error("no-root status not final");
endmodule
`default_nettype wire

>>> hw/rtl/critical_path_scheduler.sv
// Top level of the critical path scheduler: controller, datapath and output staging.
// Depends on cps_pkg, cps_ctrl and cps_datapath.
`timescale 1ns / 1ps
`default_nettype none
// A load (operation 0) stores one task. A run (operation 1) sweeps the dependency
// matrix one entry per cycle (held while a phase reports done), N sweeps forward and
// N sweeps backward for N tasks, through the single shared relaxation unit, then walks
// the zero-slack successors task by task. Each walk result is held back until the next
// result or the end of the walk is known, to learn whether it is the last. Results come
// out one per strobe and cannot be held off; the last carries last_of_path. busy drops
// in the cycle that the final result is on the outputs.
module critical_path_scheduler import cps_pkg::*; #(
  parameter int unsigned MaxTasks     = MaxTasksDef,
  parameter int unsigned DurationBits = DurationBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              operation_i,
  input  wire logic [3:0]        task_index_i,
  input  wire logic [15:0]       duration_i,
  input  wire logic [15:0]       successor_mask_i,
  input  wire logic              cfg_we_i,
  input  wire logic [CountW-1:0] cfg_wdata_i,
  output logic                   strobe,
  output logic [3:0]             path_task_o,
  output logic [TimeW-1:0]       early_finish_o,
  output logic [TimeW-1:0]       late_start_o,
  output logic                   status_o,
  output logic                   last_of_path_o
);
  logic [CountW-1:0] count_q;
  cps_cmd_t cmd;
  cps_sts_t sts;
  logic accept, emit, st, lst;
  logic [3:0] dp_task, held_task_q, out_task_q;
  logic [TimeW-1:0] dp_ef, dp_ls, held_ef_q, held_ls_q, out_ef_q, out_ls_q;
  logic held_q;

  assign accept = start && !busy;

  // Hold the task count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= CountW'(16);
    else if (cfg_we_i) count_q <= cfg_wdata_i;
  end

  cps_ctrl u_ctrl (
    .clk_i, .rst_ni, .run_i(accept && operation_i == OpRun), .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .emit_o(emit), .status_o(st), .last_o(lst)
  );

  cps_datapath #(.MaxTasks(MaxTasks), .DurationBits(DurationBits)) u_dp (
    .clk_i, .rst_ni, .load_i(accept && operation_i == OpLoad), .load_index_i(task_index_i),
    .load_duration_i(duration_i), .load_mask_i(successor_mask_i), .cfg_count_i(count_q),
    .cmd_i(cmd), .sts_o(sts), .path_task_o(dp_task), .early_finish_o(dp_ef),
    .late_start_o(dp_ls)
  );

  // Stage one walk result so the final one can be flagged; shift the staged one
  // out when the next result or the end of the walk arrives.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0; held_task_q <= '0; held_ef_q <= '0; held_ls_q <= '0;
      out_task_q <= '0; out_ef_q <= '0; out_ls_q <= '0;
    end else begin
      if (sts.emit || sts.walk_end) begin
        out_task_q <= held_task_q; out_ef_q <= held_ef_q; out_ls_q <= held_ls_q;
      end
      if (sts.emit) begin
        held_q <= 1'b1; held_task_q <= dp_task; held_ef_q <= dp_ef; held_ls_q <= dp_ls;
      end else if (lst) held_q <= 1'b0;
    end
  end

  assign strobe         = emit;
  assign path_task_o    = st ? '0 : out_task_q;
  assign early_finish_o = st ? '0 : out_ef_q;
  assign late_start_o   = st ? '0 : out_ls_q;
  assign status_o       = st;
  assign last_of_path_o = lst;

  logic unused;
  assign unused = held_q;
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for critical_path_scheduler: directed table, then random traffic.
// Depends on cps_pkg and the critical_path_scheduler RTL; holds its own scheduling predictor.
`timescale 1ns / 1ps
module testbench;
  import cps_pkg::*;

  typedef enum int {ROW_LOAD, ROW_RUN, ROW_CFG} row_kind_e;

  typedef struct {
    logic [3:0]       path_task;
    logic [TimeW-1:0] early_finish;
    logic [TimeW-1:0] late_start;
    logic             status;
    logic             last_of_path;
  } path_step_t;

  typedef struct {
    row_kind_e  kind;
    logic [3:0] index;
    logic [15:0] duration;
    logic [15:0] mask;
    bit         typed;
    path_step_t want;
  } stim_row_t;

  localparam int unsigned TimeLimit = 20'hFFFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic operation_i = OpLoad;
  logic [3:0] task_index_i = '0;
  logic [15:0] duration_i = '0;
  logic [15:0] successor_mask_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic busy, strobe, status_o, last_of_path_o;
  logic [3:0] path_task_o;
  logic [TimeW-1:0] early_finish_o, late_start_o;

  // Predictor copy of the loaded graph and the task count register
  logic [15:0] dur_mem [16];
  logic [15:0] row_mem [16];
  logic [CountW-1:0] task_count_q = CountW'(16);
  path_step_t path_q [$];
  stim_row_t tbl [$];
  int errors = 0;
  bit calm = 1'b0;

  critical_path_scheduler uut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .task_index_i, .duration_i,
    .successor_mask_i, .cfg_we_i, .cfg_wdata_i, .strobe, .path_task_o,
    .early_finish_o, .late_start_o, .status_o, .last_of_path_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned sat_add(int unsigned a, int unsigned b);
    return (a + b > TimeLimit) ? TimeLimit : a + b;
  endfunction

  function automatic int unsigned sat_sub(int unsigned a, int unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  // Append one expected result at the tail of the queue
  function automatic void expect_step(path_step_t st);
    path_q.insert(path_q.size(), st);
  endfunction

  // Append one row of directed stimulus; typed rows expect one zero-task, zero-time last result
  function automatic void add_row(row_kind_e kind, logic [3:0] index, logic [15:0] dur,
                                  logic [15:0] mask, bit typed, logic want_status);
    stim_row_t row;
    row.kind = kind;
    row.index = index;
    row.duration = dur;
    row.mask = mask;
    row.typed = typed;
    row.want = '{4'd0, '0, '0, want_status, typed};
    tbl.insert(tbl.size(), row);
  endfunction

  // Compute the critical path of the loaded graph and queue the expected results
  function automatic void plan_path();
    int unsigned n, proj, lf, c;
    int unsigned ef [16];
    int unsigned ls [16];
    bit is_root [16];
    bit is_leaf [16];
    bit seen [16];
    int stack [16];
    int sp, cnt, rt, cur;
    bit found;
    path_step_t st;
    n = (task_count_q == 0) ? 1 : ((task_count_q > 16) ? 16 : task_count_q);
    for (int i = 0; i < n; i++) begin
      is_root[i] = 1'b1;
      is_leaf[i] = 1'b1;
    end
    for (int p = 0; p < n; p++) begin
      for (int i = 0; i < n; i++) begin
        if (row_mem[p][i]) begin
          is_root[i] = 1'b0;
          is_leaf[p] = 1'b0;
        end
      end
    end
    // forward relaxation
    for (int i = 0; i < n; i++) ef[i] = is_root[i] ? dur_mem[i] : 0;
    for (int pass = 0; pass < n; pass++) begin
      for (int i = 0; i < n; i++) begin
        for (int p = 0; p < n; p++) begin
          if (row_mem[p][i]) begin
            c = sat_add(ef[p], dur_mem[i]);
            if (c > ef[i]) ef[i] = c;
          end
        end
      end
    end
    proj = 0;
    for (int i = 0; i < n; i++) if (ef[i] > proj) proj = ef[i];
    // backward relaxation, highest index first
    for (int i = 0; i < n; i++) ls[i] = sat_sub(proj, dur_mem[i]);
    for (int pass = 0; pass < n; pass++) begin
      for (int p = n - 1; p >= 0; p--) begin
        if (!is_leaf[p]) begin
          lf = TimeLimit;
          for (int s = 0; s < n; s++) if (row_mem[p][s] && ls[s] < lf) lf = ls[s];
          ls[p] = sat_sub(lf, dur_mem[p]);
        end
      end
    end
    found = 1'b0;
    rt = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && is_root[i] && ls[i] == 0) begin
        rt = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      st = '{4'd0, '0, '0, 1'b1, 1'b1};
      expect_step(st);
      return;
    end
    // walk zero-slack successors, each task once
    for (int i = 0; i < 16; i++) seen[i] = 1'b0;
    seen[rt] = 1'b1;
    st = '{rt[3:0], ef[rt][TimeW-1:0], ls[rt][TimeW-1:0], 1'b0, 1'b0};
    expect_step(st);
    cnt = 1;
    stack[0] = rt;
    sp = 1;
    while (sp > 0 && cnt < ResultLimit) begin
      sp--;
      cur = stack[sp];
      for (int j = 0; j < n && cnt < ResultLimit; j++) begin
        if (row_mem[cur][j] && !seen[j] && ls[j] == ef[cur]) begin
          seen[j] = 1'b1;
          st = '{j[3:0], ef[j][TimeW-1:0], ls[j][TimeW-1:0], 1'b0, 1'b0};
          expect_step(st);
          cnt++;
          if (sp < 16) begin
            stack[sp] = j;
            sp++;
          end
        end
      end
    end
    path_q[$].last_of_path = 1'b1;
  endfunction

  // Present one command and hold it until the transfer completes
  task automatic issue(logic op, logic [3:0] idx, logic [15:0] dur, logic [15:0] mask);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    task_index_i <= idx;
    duration_i <= dur;
    successor_mask_i <= mask;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op == OpLoad) begin
      dur_mem[idx] = dur;
      row_mem[idx] = mask;
    end else begin
      plan_path();
    end
  endtask

  // Drain all results, let the block settle, then write the task count
  task automatic write_count(logic [CountW-1:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (path_q.size() != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    task_count_q = value;
  endtask

  // Check each strobed result against the oldest expectation
  always @(posedge clk_i) begin
    path_step_t exp_s;
    if (rst_ni && strobe) begin
      if (path_q.size() == 0) begin
        $display("%0t: unexpected result task=%0d", $time, path_task_o);
        errors++;
      end else begin
        exp_s = path_q.pop_front();
        if (path_task_o !== exp_s.path_task || early_finish_o !== exp_s.early_finish ||
            late_start_o !== exp_s.late_start || status_o !== exp_s.status ||
            last_of_path_o !== exp_s.last_of_path) begin
          $display("%0t: mismatch exp task=%0d ef=%0d ls=%0d st=%0b last=%0b", $time,
                   exp_s.path_task, exp_s.early_finish, exp_s.late_start, exp_s.status,
                   exp_s.last_of_path);
          $display("%0t:          got task=%0d ef=%0d ls=%0d st=%0b last=%0b", $time,
                   path_task_o, early_finish_o, late_start_o, status_o, last_of_path_o);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t r;
    int items, burst, n_act;
    logic [3:0] idx;
    logic [15:0] dur, mask;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: zero graph, self loop (no root), count extremes, long chain.
    // Count writes carry the new count in the duration column.
    for (int i = 0; i < 16; i++) add_row(ROW_LOAD, i[3:0], 16'h0, 16'h0, 0, 1'b0);
    add_row(ROW_RUN, 4'd0, 16'h0, 16'h0, 1, 1'b0);
    add_row(ROW_CFG, 4'd0, 16'd1, 16'h0, 0, 1'b0);
    add_row(ROW_LOAD, 4'd0, 16'd5, 16'h0001, 0, 1'b0);
    add_row(ROW_RUN, 4'd0, 16'h0, 16'h0, 1, 1'b1);
    add_row(ROW_CFG, 4'd0, 16'd0, 16'h0, 0, 1'b0);
    add_row(ROW_RUN, 4'd0, 16'h0, 16'h0, 1, 1'b1);
    add_row(ROW_LOAD, 4'd0, 16'hFFFF, 16'h0002, 0, 1'b0);
    add_row(ROW_LOAD, 4'd1, 16'hFFFF, 16'h0004, 0, 1'b0);
    add_row(ROW_LOAD, 4'd2, 16'hFFFF, 16'h0000, 0, 1'b0);
    add_row(ROW_CFG, 4'd0, 16'd3, 16'h0, 0, 1'b0);
    add_row(ROW_RUN, 4'd0, 16'h0, 16'h0, 0, 1'b0);
    add_row(ROW_CFG, 4'd0, 16'd31, 16'h0, 0, 1'b0);
    add_row(ROW_LOAD, 4'd15, 16'd1234, 16'hFFFF, 0, 1'b0);
    add_row(ROW_RUN, 4'd0, 16'h0, 16'h0, 0, 1'b0);

    items = 0;
    foreach (tbl[k]) begin
      r = tbl[k];
      case (r.kind)
        ROW_LOAD: issue(OpLoad, r.index, r.duration, r.mask);
        ROW_RUN: begin
          issue(OpRun, '0, '0, '0);
          if (r.typed) begin
            void'(path_q.pop_back());
            expect_step(r.want);
          end
        end
        default: begin
          write_count(CountW'(r.duration));
        end
      endcase
      if (r.kind != ROW_CFG) items++;
    end
    write_count(CountW'(16));
    issue(OpRun, '0, '0, '0);
    items++;

    // Random part: graph edits followed by a run, count changes between bursts
    while (items < 450) begin
      calm = (items > 400);
      if (!calm && $urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 5))
          0: write_count(CountW'($urandom_range(0, 31)));
          1: write_count(CountW'(16));
          default: write_count(CountW'($urandom_range(1, 6)));
        endcase
      end
      n_act = (task_count_q == 0) ? 1 : ((task_count_q > 16) ? 16 : task_count_q);
      burst = $urandom_range(1, 6);
      for (int b = 0; b < burst; b++) begin
        idx = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, n_act - 1));
        dur = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        mask = 16'($urandom);
        // mostly forward edges only, so the graph stays mostly acyclic
        if ($urandom_range(0, 4) != 0) mask = mask & ~((16'h2 << idx) - 16'h1);
        if ($urandom_range(0, 1) == 0) mask = mask & 16'($urandom);
        issue(OpLoad, idx, dur, mask);
        items++;
      end
      issue(OpRun, '0, '0, '0);
      items++;
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (path_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && path_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/cps_pkg.sv
hw/rtl/cps_datapath.sv
hw/rtl/cps_ctrl.sv
hw/rtl/critical_path_scheduler.sv
tb/sv/testbench.sv
